>>> rtl/rtsu_pkg.sv
package rtsu_pkg;

  // shared adder width: holds a 24-bit coordinate plus a 16-bit delta with room to spare
  localparam int AluW = 26;

  localparam logic signed [AluW-1:0] Sat24Max = 26'sd8388607;
  localparam logic signed [AluW-1:0] Sat24Min = -26'sd8388608;
  localparam logic signed [AluW-1:0] Sat16Max = 26'sd32767;
  localparam logic signed [AluW-1:0] Sat16Min = -26'sd32768;

  localparam int ModeW   = 3;
  localparam int CfgIdxW = 2;
  localparam int CfgW    = 9;

  localparam logic [CfgIdxW-1:0] CFG_TREE_DEPTH   = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_SHAPE_LENGTH = 2'd1;

  typedef enum logic [ModeW-1:0] {
    MODE_WR_SPLIT = 3'd0,
    MODE_WR_LEAF  = 3'd1,
    MODE_WR_FEAT  = 3'd2,
    MODE_WR_SHAPE = 3'd3,
    MODE_EVAL     = 3'd4,
    MODE_RD_SHAPE = 3'd5
  } mode_e;

  typedef struct packed {
    logic signed [AluW-1:0] a;
    logic signed [AluW-1:0] b;
    logic                   sub;
  } alu_req_t;

  typedef struct packed {
    logic signed [AluW-1:0] sum;
    logic signed [23:0]     sat24;
    logic                   sat24_hit;
    logic signed [15:0]     sat16;
    logic                   sat16_hit;
  } alu_res_t;

endpackage

>>> rtl/rtsu_alu.sv
module rtsu_alu (
  input  rtsu_pkg::alu_req_t req_i,
  output rtsu_pkg::alu_res_t res_o
);
  import rtsu_pkg::*;

  logic signed [AluW-1:0] sum;

  always_comb begin
    sum = req_i.sub ? (req_i.a - req_i.b) : (req_i.a + req_i.b);

    res_o.sum = sum;

    if (sum > Sat24Max) begin
      res_o.sat24     = 24'sh7fffff;
      res_o.sat24_hit = 1'b1;
    end else if (sum < Sat24Min) begin
      res_o.sat24     = 24'sh800000;
      res_o.sat24_hit = 1'b1;
    end else begin
      res_o.sat24     = sum[23:0];
      res_o.sat24_hit = 1'b0;
    end

    if (sum > Sat16Max) begin
      res_o.sat16     = 16'sh7fff;
      res_o.sat16_hit = 1'b1;
    end else if (sum < Sat16Min) begin
      res_o.sat16     = 16'sh8000;
      res_o.sat16_hit = 1'b1;
    end else begin
      res_o.sat16     = sum[15:0];
      res_o.sat16_hit = 1'b0;
    end
  end

endmodule

>>> rtl/regression_tree_shape_update_unit.sv
// channel   direction  handshake                  payload
// cfg       in         cfg_we_i                   cfg_index_i, cfg_data_i
// in        in         in_valid_i / in_ready_o    mode, table_index, pixels, threshold,
//                                                 element_index, value
// out       out        out_valid_o / out_ready_i  done_mode, leaf_reached, read_value, saturated
//
// One word at a time through a small sequencer around one shared add/compare/saturate unit.
// Evaluate walks the tree level by level (split read, two feature reads on the single
// feature port, subtract, compare), then updates one coordinate per cycle. A shape read
// waits on the shape store read; writes and unknown modes go straight to the result.
// in_ready_o is high only while idle; a finished word sits in the output register, so the
// next word is taken while it waits. Reset initialises control and config only; stores are
// undefined until written.
module regression_tree_shape_update_unit #(
  parameter int MAX_TREE_DEPTH = 6,
  parameter int FEATURE_COUNT  = 512,
  parameter int SHAPE_MAX      = 256
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [rtsu_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [rtsu_pkg::CfgW-1:0]     cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [2:0]                    mode_i,
  input  logic [5:0]                    table_index_i,
  input  logic [8:0]                    first_pixel_i,
  input  logic [8:0]                    second_pixel_i,
  input  logic signed [16:0]            threshold_i,
  input  logic [7:0]                    element_index_i,
  input  logic signed [23:0]            value_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [2:0]                    done_mode_o,
  output logic [5:0]                    leaf_reached_o,
  output logic signed [23:0]            read_value_o,
  output logic                          saturated_o
);
  import rtsu_pkg::*;

  localparam int NW      = MAX_TREE_DEPTH;
  localparam int IW      = MAX_TREE_DEPTH + 1;
  localparam int NodeCap = (1 << MAX_TREE_DEPTH) - 1;
  localparam int LeafCap = 1 << MAX_TREE_DEPTH;
  localparam int FW      = $clog2(FEATURE_COUNT);
  localparam int SW      = $clog2(SHAPE_MAX);
  localparam int KW      = $clog2(SHAPE_MAX + 1);
  localparam int LAW     = MAX_TREE_DEPTH + SW;
  localparam int DepW    = $clog2(MAX_TREE_DEPTH + 1);

  typedef enum logic [9:0] {
    ST_IDLE   = 10'b0000000001,
    ST_EXEC   = 10'b0000000010,
    ST_RDWAIT = 10'b0000000100,
    ST_NODE   = 10'b0000001000,
    ST_FEAT1  = 10'b0000010000,
    ST_FEAT2  = 10'b0000100000,
    ST_DIFF   = 10'b0001000000,
    ST_CMP    = 10'b0010000000,
    ST_UPD    = 10'b0100000000,
    ST_DONE   = 10'b1000000000
  } state_e;

  typedef struct packed {
    logic [8:0]         p1;
    logic [8:0]         p2;
    logic signed [16:0] thr;
  } split_t;

  // stores
  split_t             split_mem [NodeCap];
  logic signed [15:0] leaf_mem  [2**LAW];
  logic signed [15:0] feat_mem  [FEATURE_COUNT];
  logic signed [23:0] shape_mem [SHAPE_MAX];

  split_t             split_rd;
  logic signed [15:0] leaf_rd;
  logic signed [15:0] feat_rd;
  logic signed [23:0] shape_rd;

  logic [NW-1:0]      split_ra;
  logic [8:0]         feat_ra;
  logic [SW-1:0]      shape_ra;
  logic [LAW-1:0]     leaf_ra;
  logic               split_we, leaf_we, feat_we, shape_we;
  logic [SW-1:0]      shape_wa;
  logic signed [23:0] shape_wd;

  alu_req_t alu_req;
  alu_res_t alu_res;

  state_e state_q, state_d;
  logic [2:0] tree_depth_q;
  logic [8:0] shape_len_q;
  logic       out_valid_q, out_valid_d, load_out;

  mode_e              mode_q, mode_d;
  logic [5:0]         tix_q, tix_d;
  logic [8:0]         p1_q, p1_d, p2_q, p2_d;
  logic signed [16:0] thr_q, thr_d;
  logic [7:0]         eix_q, eix_d;
  logic signed [23:0] val_q, val_d;

  logic [IW-1:0]      node_q, node_d, nsplit_q, nsplit_d, node_next;
  logic [KW-1:0]      len_q, len_d, k_q, k_d;
  logic               wb_v_q, wb_v_d;
  logic [SW-1:0]      wb_k_q, wb_k_d;
  logic [NW-1:0]      leaf_q, leaf_d;
  logic signed [15:0] f1_q, f1_d, f2;
  logic [8:0]         np2_q, np2_d;
  logic signed [16:0] nthr_q, nthr_d;
  logic signed [16:0] diff_q, diff_d;
  logic               feat_oob_q;
  logic [5:0]         res_leaf_q, res_leaf_d;
  logic signed [23:0] res_rd_q, res_rd_d;
  logic               res_sat_q, res_sat_d;

  mode_e              out_mode_q;
  logic [5:0]         out_leaf_q;
  logic signed [23:0] out_rd_q;
  logic               out_sat_q;

  logic [DepW-1:0]    depth_cl;
  logic [KW-1:0]      len_cl;
  logic               eix_ok;

  rtsu_alu u_alu (
    .req_i (alu_req),
    .res_o (alu_res)
  );

  // register values clamped to their legal ranges
  always_comb begin
    if (tree_depth_q == 3'd0) begin
      depth_cl = DepW'(1);
    end else if (32'(tree_depth_q) > MAX_TREE_DEPTH) begin
      depth_cl = DepW'(MAX_TREE_DEPTH);
    end else begin
      depth_cl = DepW'(tree_depth_q);
    end
    if (shape_len_q == 9'd0) begin
      len_cl = KW'(1);
    end else if (32'(shape_len_q) > SHAPE_MAX) begin
      len_cl = KW'(SHAPE_MAX);
    end else begin
      len_cl = KW'(shape_len_q);
    end
  end

  assign eix_ok = 32'(eix_q) < SHAPE_MAX;
  assign f2     = feat_oob_q ? 16'sd0 : feat_rd;

  always_comb begin
    state_d    = state_q;
    mode_d     = mode_q;
    tix_d      = tix_q;
    p1_d       = p1_q;
    p2_d       = p2_q;
    thr_d      = thr_q;
    eix_d      = eix_q;
    val_d      = val_q;
    node_d     = node_q;
    nsplit_d   = nsplit_q;
    len_d      = len_q;
    k_d        = k_q;
    wb_v_d     = wb_v_q;
    wb_k_d     = wb_k_q;
    leaf_d     = leaf_q;
    f1_d       = f1_q;
    np2_d      = np2_q;
    nthr_d     = nthr_q;
    diff_d     = diff_q;
    res_leaf_d = res_leaf_q;
    res_rd_d   = res_rd_q;
    res_sat_d  = res_sat_q;
    load_out   = 1'b0;
    node_next  = '0;

    alu_req  = '0;
    split_we = 1'b0;
    leaf_we  = 1'b0;
    feat_we  = 1'b0;
    shape_we = 1'b0;
    shape_wa = SW'(eix_q);
    shape_wd = val_q;
    split_ra = node_q[NW-1:0];
    feat_ra  = split_rd.p1;
    shape_ra = k_q[SW-1:0];
    leaf_ra  = {leaf_q, k_q[SW-1:0]};

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          mode_d  = mode_e'(mode_i);
          tix_d   = table_index_i;
          p1_d    = first_pixel_i;
          p2_d    = second_pixel_i;
          thr_d   = threshold_i;
          eix_d   = element_index_i;
          val_d   = value_i;
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        alu_req.a  = {{(AluW-24){val_q[23]}}, val_q};
        res_leaf_d = '0;
        res_rd_d   = '0;
        res_sat_d  = 1'b0;
        state_d    = ST_DONE;
        case (mode_q)
          MODE_WR_SPLIT: begin
            split_we = 32'(tix_q) < NodeCap;
          end
          MODE_WR_LEAF: begin
            res_sat_d = alu_res.sat16_hit;
            leaf_we   = (32'(tix_q) < LeafCap) && eix_ok;
          end
          MODE_WR_FEAT: begin
            res_sat_d = alu_res.sat16_hit;
            feat_we   = 32'(p1_q) < FEATURE_COUNT;
          end
          MODE_WR_SHAPE: begin
            shape_we = eix_ok;
          end
          MODE_EVAL: begin
            node_d   = '0;
            nsplit_d = IW'((1 << depth_cl) - 1);
            len_d    = len_cl;
            state_d  = ST_NODE;
          end
          MODE_RD_SHAPE: begin
            shape_ra = SW'(eix_q);
            state_d  = ST_RDWAIT;
          end
          default: ;
        endcase
      end
      ST_RDWAIT: begin
        res_rd_d = eix_ok ? shape_rd : 24'sd0;
        state_d  = ST_DONE;
      end
      ST_NODE: begin
        state_d = ST_FEAT1;
      end
      ST_FEAT1: begin
        feat_ra = split_rd.p1;
        np2_d   = split_rd.p2;
        nthr_d  = split_rd.thr;
        state_d = ST_FEAT2;
      end
      ST_FEAT2: begin
        feat_ra = np2_q;
        f1_d    = feat_oob_q ? 16'sd0 : feat_rd;
        state_d = ST_DIFF;
      end
      ST_DIFF: begin
        alu_req.a   = {{(AluW-16){f1_q[15]}}, f1_q};
        alu_req.b   = {{(AluW-16){f2[15]}}, f2};
        alu_req.sub = 1'b1;
        diff_d      = alu_res.sum[16:0];
        state_d     = ST_CMP;
      end
      ST_CMP: begin
        // threshold - diff < 0 means diff > threshold: take the first child
        alu_req.a   = {{(AluW-17){nthr_q[16]}}, nthr_q};
        alu_req.b   = {{(AluW-17){diff_q[16]}}, diff_q};
        alu_req.sub = 1'b1;
        node_next   = alu_res.sum[AluW-1] ? ({node_q[IW-2:0], 1'b0} + IW'(1))
                                          : ({node_q[IW-2:0], 1'b0} + IW'(2));
        node_d      = node_next;
        if (node_next >= nsplit_q) begin
          leaf_d  = NW'(node_next - nsplit_q);
          k_d     = '0;
          wb_v_d  = 1'b0;
          state_d = ST_UPD;
        end else begin
          state_d = ST_NODE;
        end
      end
      ST_UPD: begin
        // read coordinate k while coordinate k-1 is summed and written back
        wb_v_d = k_q < len_q;
        wb_k_d = k_q[SW-1:0];
        if (k_q < len_q) begin
          k_d = k_q + KW'(1);
        end
        if (wb_v_q) begin
          alu_req.a = {{(AluW-24){shape_rd[23]}}, shape_rd};
          alu_req.b = {{(AluW-16){leaf_rd[15]}}, leaf_rd};
          shape_we  = 1'b1;
          shape_wa  = wb_k_q;
          shape_wd  = alu_res.sat24;
          res_sat_d = res_sat_q | alu_res.sat24_hit;
        end
        if ((k_q == len_q) && !wb_v_q) begin
          res_leaf_d = 6'(leaf_q);
          state_d    = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          load_out = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign out_valid_d = (out_valid_q & ~out_ready_i) | load_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      out_valid_q  <= 1'b0;
      wb_v_q       <= 1'b0;
      tree_depth_q <= 3'd4;
      shape_len_q  <= 9'd136;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      wb_v_q      <= wb_v_d;
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CFG_TREE_DEPTH:   tree_depth_q <= cfg_data_i[2:0];
          CFG_SHAPE_LENGTH: shape_len_q  <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q     <= mode_d;
    tix_q      <= tix_d;
    p1_q       <= p1_d;
    p2_q       <= p2_d;
    thr_q      <= thr_d;
    eix_q      <= eix_d;
    val_q      <= val_d;
    node_q     <= node_d;
    nsplit_q   <= nsplit_d;
    len_q      <= len_d;
    k_q        <= k_d;
    wb_k_q     <= wb_k_d;
    leaf_q     <= leaf_d;
    f1_q       <= f1_d;
    np2_q      <= np2_d;
    nthr_q     <= nthr_d;
    diff_q     <= diff_d;
    res_leaf_q <= res_leaf_d;
    res_rd_q   <= res_rd_d;
    res_sat_q  <= res_sat_d;
    if (load_out) begin
      out_mode_q <= mode_q;
      out_leaf_q <= res_leaf_q;
      out_rd_q   <= res_rd_q;
      out_sat_q  <= res_sat_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (split_we) begin
      split_mem[NW'(tix_q)] <= '{p1: p1_q, p2: p2_q, thr: thr_q};
    end
    split_rd <= split_mem[split_ra];
  end

  always_ff @(posedge clk_i) begin
    if (leaf_we) begin
      leaf_mem[{NW'(tix_q), SW'(eix_q)}] <= alu_res.sat16;
    end
    leaf_rd <= leaf_mem[leaf_ra];
  end

  // out-of-range pixel index reads as zero
  always_ff @(posedge clk_i) begin
    if (feat_we) begin
      feat_mem[FW'(p1_q)] <= alu_res.sat16;
    end
    feat_rd    <= feat_mem[FW'(feat_ra)];
    feat_oob_q <= 32'(feat_ra) >= FEATURE_COUNT;
  end

  always_ff @(posedge clk_i) begin
    if (shape_we) begin
      shape_mem[shape_wa] <= shape_wd;
    end
    shape_rd <= shape_mem[shape_ra];
  end

  assign in_ready_o     = (state_q == ST_IDLE);
  assign out_valid_o    = out_valid_q;
  assign done_mode_o    = out_mode_q;
  assign leaf_reached_o = out_leaf_q;
  assign read_value_o   = out_rd_q;
  assign saturated_o    = out_sat_q;

endmodule

>>> sim/regression_tree_shape_update_unit_test.sv
module regression_tree_shape_update_unit_test;
  import rtsu_pkg::*;

  localparam int TreeMax    = 6;
  localparam int FeatCount  = 512;
  localparam int ShapeMax   = 256;
  localparam int NodeCap    = (1 << TreeMax) - 1;
  localparam int LeafCap    = 1 << TreeMax;
  localparam int HoldCycles = 400;
  localparam int EndSettle  = 5 * TreeMax + ShapeMax + 8;

  localparam logic [ModeW-1:0]   MODE_SPARE_6 = 3'd6;
  localparam logic [ModeW-1:0]   MODE_SPARE_7 = 3'd7;
  localparam logic [CfgIdxW-1:0] CFG_SPARE_2  = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_SPARE_3  = 2'd3;

  typedef struct packed {
    logic [2:0]         mode;
    logic [5:0]         tix;
    logic [8:0]         p1;
    logic [8:0]         p2;
    logic signed [16:0] thr;
    logic [7:0]         eix;
    logic signed [23:0] value;
  } in_word_t;

  typedef struct packed {
    logic [2:0]         mode;
    logic [5:0]         leaf;
    logic signed [23:0] rd;
    logic               sat;
  } out_word_t;

  // mirror of the tree, feature and shape stores plus the queue of owed result words
  class shape_unit_board;
    int unsigned depth_reg = 4;
    int unsigned len_reg = 136;
    logic [8:0]         split_a [NodeCap];
    logic [8:0]         split_b [NodeCap];
    logic signed [16:0] split_thr [NodeCap];
    logic signed [15:0] leaf_delta [LeafCap*ShapeMax];
    logic signed [15:0] feature [FeatCount];
    logic signed [23:0] shape [ShapeMax];
    bit split_set [NodeCap];
    bit leaf_set [LeafCap*ShapeMax];
    bit feat_set [FeatCount];
    bit shape_set [ShapeMax];
    out_word_t owed [$];
    int unsigned errors, n_words, n_walks, n_reads, n_clipped;

    function int unsigned eff_depth();
      if (depth_reg < 1) return 1;
      if (depth_reg > TreeMax) return TreeMax;
      return depth_reg;
    endfunction

    function int unsigned eff_len();
      if (len_reg < 1) return 1;
      if (len_reg > ShapeMax) return ShapeMax;
      return len_reg;
    endfunction

    function void set_reg(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] data);
      if (idx == CFG_TREE_DEPTH) depth_reg = data[2:0];
      else if (idx == CFG_SHAPE_LENGTH) len_reg = data;
    endfunction

    function int unsigned next_node(int unsigned i);
      int diff;
      diff = int'(feature[split_a[i]]) - int'(feature[split_b[i]]);
      if (diff > int'(split_thr[i])) return 2 * i + 1;
      return 2 * i + 2;
    endfunction

    function logic signed [15:0] clip16(logic signed [23:0] v, inout bit hit);
      if (int'(v) > int'(Sat16Max)) begin
        hit = 1'b1;
        return 16'h7FFF;
      end
      if (int'(v) < int'(Sat16Min)) begin
        hit = 1'b1;
        return 16'h8000;
      end
      return v[15:0];
    endfunction

    function void take_word(in_word_t w);
      out_word_t r;
      bit hit;
      int unsigned nsplit, node, leaf, len, k, slot;
      int sum;
      r = '0;
      r.mode = w.mode;
      hit = 1'b0;
      n_words++;
      case (w.mode)
        MODE_WR_SPLIT: begin
          if (w.tix < NodeCap) begin
            split_a[w.tix] = w.p1;
            split_b[w.tix] = w.p2;
            split_thr[w.tix] = w.thr;
            split_set[w.tix] = 1'b1;
          end
        end
        MODE_WR_LEAF: begin
          slot = int'(w.tix) * ShapeMax + int'(w.eix);
          leaf_delta[slot] = clip16(w.value, hit);
          leaf_set[slot] = 1'b1;
        end
        MODE_WR_FEAT: begin
          feature[w.p1] = clip16(w.value, hit);
          feat_set[w.p1] = 1'b1;
        end
        MODE_WR_SHAPE: begin
          shape[w.eix] = w.value;
          shape_set[w.eix] = 1'b1;
        end
        MODE_EVAL: begin
          nsplit = (1 << eff_depth()) - 1;
          node = 0;
          while (node < nsplit) node = next_node(node);
          leaf = node - nsplit;
          len = eff_len();
          for (k = 0; k < len; k++) begin
            sum = int'(shape[k]) + int'(leaf_delta[leaf * ShapeMax + k]);
            if (sum > int'(Sat24Max)) begin
              sum = int'(Sat24Max);
              hit = 1'b1;
            end else if (sum < int'(Sat24Min)) begin
              sum = int'(Sat24Min);
              hit = 1'b1;
            end
            shape[k] = sum[23:0];
          end
          r.leaf = leaf[5:0];
          n_walks++;
        end
        MODE_RD_SHAPE: begin
          r.rd = shape[w.eix];
          n_reads++;
        end
        default: ;
      endcase
      r.sat = hit;
      owed = {owed, r};
    endfunction

    task report(string what);
      errors++;
      if (errors <= 40) $display("mismatch %0d: %s", errors, what);
    endtask

    task check_word(out_word_t got);
      out_word_t want;
      if (got.sat) n_clipped++;
      if (owed.size() == 0) begin
        report($sformatf("result word with none owed (mode %0d)", got.mode));
        return;
      end
      want = owed.pop_front();
      if (got.mode !== want.mode)
        report($sformatf("done_mode %0d, want %0d", got.mode, want.mode));
      if (got.leaf !== want.leaf)
        report($sformatf("mode %0d leaf_reached %0d, want %0d", want.mode, got.leaf, want.leaf));
      if (got.rd !== want.rd)
        report($sformatf("mode %0d read_value %0d, want %0d", want.mode, got.rd, want.rd));
      if (got.sat !== want.sat)
        report($sformatf("mode %0d saturated %0b, want %0b", want.mode, got.sat, want.sat));
    endtask
  endclass

  logic                     clk_i;
  logic                     rst_ni;
  logic                     cfg_we_i;
  logic [CfgIdxW-1:0]       cfg_index_i;
  logic [CfgW-1:0]          cfg_data_i;
  logic                     in_valid_i;
  logic                     in_ready_o;
  logic [2:0]               mode_i;
  logic [5:0]               table_index_i;
  logic [8:0]               first_pixel_i;
  logic [8:0]               second_pixel_i;
  logic signed [16:0]       threshold_i;
  logic [7:0]               element_index_i;
  logic signed [23:0]       value_i;
  logic                     out_valid_o;
  logic                     out_ready_i;
  logic [2:0]               done_mode_o;
  logic [5:0]               leaf_reached_o;
  logic signed [23:0]       read_value_o;
  logic                     saturated_o;

  shape_unit_board sb = new;
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned hold_asks = 0;

  regression_tree_shape_update_unit #(
    .MAX_TREE_DEPTH(TreeMax),
    .FEATURE_COUNT (FeatCount),
    .SHAPE_MAX     (ShapeMax)
  ) uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .mode_i         (mode_i),
    .table_index_i  (table_index_i),
    .first_pixel_i  (first_pixel_i),
    .second_pixel_i (second_pixel_i),
    .threshold_i    (threshold_i),
    .element_index_i(element_index_i),
    .value_i        (value_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .done_mode_o    (done_mode_o),
    .leaf_reached_o (leaf_reached_o),
    .read_value_o   (read_value_o),
    .saturated_o    (saturated_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #6_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  // receiver: random stalls, plus a long hold-off whenever one is asked for
  initial begin : receiver
    int unsigned left;
    int unsigned seen;
    left = 0;
    seen = 0;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_asks != seen) begin
        seen = hold_asks;
        left = HoldCycles;
      end
      if (left != 0) begin
        left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin : monitor
    out_word_t got;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got.mode = done_mode_o;
      got.leaf = leaf_reached_o;
      got.rd = read_value_o;
      got.sat = saturated_o;
      sb.check_word(got);
    end
  end

  function automatic in_word_t word_of(logic [2:0] mode, logic [5:0] tix, logic [8:0] p1,
                                       logic [8:0] p2, logic signed [16:0] thr,
                                       logic [7:0] eix, logic signed [23:0] value);
    in_word_t w;
    w.mode = mode;
    w.tix = tix;
    w.p1 = p1;
    w.p2 = p2;
    w.thr = thr;
    w.eix = eix;
    w.value = value;
    return w;
  endfunction

  function automatic in_word_t rand_word();
    in_word_t w;
    w.mode = MODE_SPARE_6;
    w.tix = 6'($urandom);
    w.p1 = 9'($urandom);
    w.p2 = 9'($urandom);
    w.thr = 17'($urandom);
    w.eix = 8'($urandom);
    w.value = 24'($urandom);
    return w;
  endfunction

  function automatic logic signed [23:0] rand_delta();
    int v;
    case ($urandom_range(9))
      0: begin
        case ($urandom_range(7))
          0: return 24'h7FFFFF;
          1: return 24'h800000;
          2: return 24'h007FFF;
          3: return 24'h008000;
          4: return 24'hFF8000;
          5: return 24'hFF7FFF;
          6: return 24'h000000;
          default: return 24'hFFFFFF;
        endcase
      end
      1: return 24'($urandom);
      default: begin
        v = int'($urandom_range(65535)) - 32768;
        return 24'(v);
      end
    endcase
  endfunction

  // mostly moderate coordinates; some near the rails so walks clip
  function automatic logic signed [23:0] rand_coord();
    int v;
    case ($urandom_range(7))
      0: v = 8388607 - int'($urandom_range(40000));
      1: v = -8388608 + int'($urandom_range(40000));
      2: v = int'($urandom);
      default: v = int'($urandom_range(2097151)) - 1048576;
    endcase
    return 24'(v);
  endfunction

  function automatic logic signed [16:0] rand_thr();
    int v;
    case ($urandom_range(7))
      0: return 17'h0FFFF;
      1: return 17'h10000;
      2: return 17'($urandom);
      default: begin
        v = int'($urandom_range(8192)) - 4096;
        return 17'(v);
      end
    endcase
  endfunction

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] data);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_reg(idx, data);
  endtask

  task automatic send_word(in_word_t w);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    mode_i <= w.mode;
    table_index_i <= w.tix;
    first_pixel_i <= w.p1;
    second_pixel_i <= w.p2;
    threshold_i <= w.thr;
    element_index_i <= w.eix;
    value_i <= w.value;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.take_word(w);
  endtask

  task automatic drain_results();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.owed.size() != 0) @(posedge clk_i);
  endtask

  task automatic begin_phase(logic [CfgW-1:0] depth, logic [CfgW-1:0] len,
                             int unsigned idle, int unsigned stall);
    drain_results();
    write_reg(CFG_TREE_DEPTH, depth);
    write_reg(CFG_SHAPE_LENGTH, len);
    send_idle_pct = idle;
    stall_pct = stall;
  endtask

  // fill in whatever the walk will touch, then evaluate
  task automatic run_tree_walk();
    in_word_t w;
    int unsigned nsplit, node, leaf, len, k;
    nsplit = (1 << sb.eff_depth()) - 1;
    node = 0;
    while (node < nsplit) begin
      if (!sb.split_set[node]) begin
        w = rand_word();
        w.mode = MODE_WR_SPLIT;
        w.tix = node[5:0];
        w.thr = rand_thr();
        send_word(w);
      end
      if (!sb.feat_set[sb.split_a[node]]) begin
        w = rand_word();
        w.mode = MODE_WR_FEAT;
        w.p1 = sb.split_a[node];
        w.value = rand_delta();
        send_word(w);
      end
      if (!sb.feat_set[sb.split_b[node]]) begin
        w = rand_word();
        w.mode = MODE_WR_FEAT;
        w.p1 = sb.split_b[node];
        w.value = rand_delta();
        send_word(w);
      end
      node = sb.next_node(node);
    end
    leaf = node - nsplit;
    len = sb.eff_len();
    for (k = 0; k < len; k++) begin
      if (!sb.leaf_set[leaf * ShapeMax + k]) begin
        w = rand_word();
        w.mode = MODE_WR_LEAF;
        w.tix = leaf[5:0];
        w.eix = k[7:0];
        w.value = rand_delta();
        send_word(w);
      end
      if (!sb.shape_set[k]) begin
        w = rand_word();
        w.mode = MODE_WR_SHAPE;
        w.eix = k[7:0];
        w.value = rand_coord();
        send_word(w);
      end
    end
    w = rand_word();
    w.mode = MODE_EVAL;
    send_word(w);
  endtask

  task automatic random_action();
    in_word_t w;
    int unsigned pick;
    pick = $urandom_range(99);
    w = rand_word();
    if (pick < 30) begin
      run_tree_walk();
    end else begin
      if (pick < 40) begin
        w.mode = MODE_RD_SHAPE;
        if (!sb.shape_set[w.eix]) w.eix = 8'($urandom_range(sb.eff_len() - 1));
        if (!sb.shape_set[w.eix]) begin
          w.mode = MODE_WR_SHAPE;
          w.value = rand_coord();
        end
      end else if (pick < 55) begin
        w.mode = MODE_WR_SPLIT;
        w.thr = rand_thr();
      end else if (pick < 68) begin
        w.mode = MODE_WR_FEAT;
        w.value = rand_delta();
      end else if (pick < 80) begin
        w.mode = MODE_WR_LEAF;
        w.value = rand_delta();
        if ($urandom_range(3) != 0) w.eix = 8'($urandom_range(sb.eff_len() - 1));
      end else if (pick < 93) begin
        w.mode = MODE_WR_SHAPE;
        w.value = rand_coord();
      end else begin
        w.mode = ($urandom_range(1) == 0) ? MODE_SPARE_6 : MODE_SPARE_7;
      end
      send_word(w);
    end
  endtask

  initial begin : stimulus
    int unsigned stop_at;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    mode_i = '0;
    table_index_i = '0;
    first_pixel_i = '0;
    second_pixel_i = '0;
    threshold_i = '0;
    element_index_i = '0;
    value_i = '0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: edge values, clipped writes, ignored node, spare modes and indexes
    write_reg(CFG_TREE_DEPTH, 9'd2);
    write_reg(CFG_SHAPE_LENGTH, 9'd4);
    write_reg(CFG_SPARE_2, 9'h1FF);
    write_reg(CFG_SPARE_3, 9'h1FF);
    send_word(word_of(MODE_WR_FEAT, 0, 0, 0, 0, 0, 24'h007FFF));
    send_word(word_of(MODE_WR_FEAT, 0, 511, 0, 0, 0, 24'hFF8000));
    send_word(word_of(MODE_WR_FEAT, 0, 1, 0, 0, 0, 24'h7FFFFF));
    send_word(word_of(MODE_WR_FEAT, 0, 2, 0, 0, 0, 24'h800000));
    send_word(word_of(MODE_WR_FEAT, 0, 3, 0, 0, 0, 24'h008000));
    send_word(word_of(MODE_WR_SPLIT, 0, 0, 511, 17'h10000, 0, 0));
    send_word(word_of(MODE_WR_SPLIT, 1, 511, 0, 17'h0FFFF, 0, 0));
    send_word(word_of(MODE_WR_SPLIT, 2, 1, 2, 0, 0, 0));
    send_word(word_of(MODE_WR_SPLIT, 63, 511, 511, 17'h0FFFF, 255, 24'hFFFFFF));
    send_word(word_of(MODE_WR_SHAPE, 0, 0, 0, 0, 0, 24'h7FFFFF));
    send_word(word_of(MODE_WR_SHAPE, 0, 0, 0, 0, 1, 24'h800000));
    send_word(word_of(MODE_WR_SHAPE, 0, 0, 0, 0, 255, 24'd12345));
    // the first walk lands on leaf 1 and pushes both rails
    send_word(word_of(MODE_WR_LEAF, 1, 0, 0, 0, 0, 24'h007FFF));
    send_word(word_of(MODE_WR_LEAF, 1, 0, 0, 0, 1, 24'hFF8000));
    send_word(word_of(MODE_WR_LEAF, 63, 0, 0, 0, 255, 24'h800000));
    send_word(word_of(MODE_SPARE_6, 63, 511, 511, 17'h1FFFF, 255, 24'hFFFFFF));
    send_word(word_of(MODE_SPARE_7, 0, 0, 0, 0, 0, 0));
    run_tree_walk();
    send_word(word_of(MODE_RD_SHAPE, 0, 0, 0, 0, 0, 0));
    send_word(word_of(MODE_RD_SHAPE, 0, 0, 0, 0, 1, 0));
    send_word(word_of(MODE_RD_SHAPE, 0, 0, 0, 0, 255, 0));
    // difference equal to threshold goes right
    send_word(word_of(MODE_WR_SPLIT, 0, 0, 511, 17'h0FFFF, 0, 0));
    run_tree_walk();

    begin_phase(9'd3, 9'd8, 0, 0);
    stop_at = sb.n_words + 300;
    while (sb.n_words < stop_at) random_action();

    begin_phase(9'd6, 9'd1, 53, 0);
    stop_at = sb.n_words + 250;
    while (sb.n_words < stop_at) random_action();

    begin_phase(9'd0, 9'd0, 0, 53);
    stop_at = sb.n_words + 200;
    while (sb.n_words < stop_at) random_action();

    begin_phase(9'd7, 9'd16, 14, 14);
    hold_asks++;
    stop_at = sb.n_words + 250;
    while (sb.n_words < stop_at) random_action();

    begin_phase(9'd1, 9'd256, 0, 0);
    stop_at = sb.n_words + 60;
    while (sb.n_words < stop_at) random_action();

    begin_phase(9'd1, 9'd511, 0, 53);
    stop_at = sb.n_words + 100;
    while (sb.n_words < stop_at) random_action();

    // upper data bits set on the depth write: only the low three count
    begin_phase(9'h0F5, 9'd6, 14, 14);
    stop_at = sb.n_words + 200;
    while (sb.n_words < stop_at) random_action();

    drain_results();
    repeat (EndSettle) @(posedge clk_i);
    $display("run covered %0d words: %0d tree walks, %0d shape reads, %0d clipped results",
             sb.n_words, sb.n_walks, sb.n_reads, sb.n_clipped);
    $display("depth 1 to 6, shape lengths 1 to 256, stalls on both sides and a long hold-off");
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
